/* src/hlmdu_pkg.sv */
// Package for the HI/LO multiply-divide unit: operand widths and opcodes, and
// the small opcode helpers of the top level. The widths also serve its bit-serial units.
// No dependencies.
`default_nettype none

package hlmdu_pkg;

   localparam int DATA_W = 32;
   localparam int PROD_W = 2 * DATA_W;
   localparam int CNT_W  = $clog2(DATA_W);
   localparam int REG_W  = 5;
   localparam int OP_W   = 3;

   typedef enum logic [OP_W-1:0] {
      OP_MULT  = 3'd0,
      OP_MULTU = 3'd1,
      OP_MADD  = 3'd2,
      OP_MADDU = 3'd3,
      OP_DIV   = 3'd4,
      OP_DIVU  = 3'd5
   } op_type;

   function automatic logic is_mul_op(input logic [OP_W-1:0] op);
      return (op == OP_MULT) || (op == OP_MULTU) || (op == OP_MADD) || (op == OP_MADDU);
   endfunction

   function automatic logic is_div_op(input logic [OP_W-1:0] op);
      return (op == OP_DIV) || (op == OP_DIVU);
   endfunction

   function automatic logic is_signed_op(input logic [OP_W-1:0] op);
      return (op == OP_MULT) || (op == OP_MADD) || (op == OP_DIV);
   endfunction

   function automatic logic is_acc_op(input logic [OP_W-1:0] op);
      return (op == OP_MADD) || (op == OP_MADDU);
   endfunction

endpackage

`default_nettype wire

/* src/hlmdu_mul.sv */
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on hlmdu_pkg for the operand widths.
`default_nettype none

module hlmdu_mul (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [hlmdu_pkg::DATA_W-1:0] mcand,
   input  wire logic [hlmdu_pkg::DATA_W-1:0] mplier,
   output logic                              done,
   output logic [hlmdu_pkg::PROD_W-1:0]      product
);
   import hlmdu_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [DATA_W-1:0]   mcand_ff, mcand_in;
   logic [DATA_W:0]     sum;

   always_comb begin
      sum = {1'b0, prod_ff[PROD_W-1:DATA_W]} +
            {1'b0, (prod_ff[0] ? mcand_ff : {DATA_W{1'b0}})};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      mcand_in = mcand_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         prod_in  = {{DATA_W{1'b0}}, mplier};
         mcand_in = mcand;
      end else if (busy_ff) begin
         prod_in = {sum, prod_ff[DATA_W-1:1]};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      prod_ff  <= prod_in;
      mcand_ff <= mcand_in;
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

`default_nettype wire

/* src/hlmdu_div.sv */
// Bit-serial unsigned restoring divider, one quotient bit per cycle.
// Depends on hlmdu_pkg for the operand widths.
`default_nettype none

module hlmdu_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [hlmdu_pkg::DATA_W-1:0] dividend,
   input  wire logic [hlmdu_pkg::DATA_W-1:0] divisor,
   output logic                              done,
   output logic [hlmdu_pkg::DATA_W-1:0]      quotient,
   output logic [hlmdu_pkg::DATA_W-1:0]      remainder
);
   import hlmdu_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DATA_W-1:0]   rem_ff, rem_in;
   logic [DATA_W-1:0]   quo_ff, quo_in;
   logic [DATA_W-1:0]   dvsr_ff, dvsr_in;
   logic [DATA_W:0]     shifted;
   logic [DATA_W+1:0]   diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[DATA_W-1]};
      diff    = {1'b0, shifted} - {2'b00, dvsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvsr_in = dvsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvsr_in = divisor;
      end else if (busy_ff) begin
         if (diff[DATA_W+1]) begin
            rem_in = shifted[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end else begin
            rem_in = diff[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvsr_ff <= dvsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

/* src/hilo_multiply_divide_unit.sv */
// Top level of the HI/LO multiply-divide unit: handshake, HI/LO registers of
// both pipes, sign handling and accumulation around the serial units.
// Depends on hlmdu_pkg, hlmdu_mul and hlmdu_div.
//
// One request transaction carries an instruction: opcode and pipe select in
// req_tuser, the two operands and the destination index in req_tdata. For each
// request exactly one response transaction returns the new HI and LO of the
// chosen pipe and the destination write flag and index.
// Multiplies and divides run through a shift-add multiplier or a restoring
// divider that resolve one bit per cycle. Operand magnitudes enter the serial
// unit on acceptance (ST_RUN); then come ST_FIX (sign fix-up), ST_ACC
// (accumulation into HI/LO) and ST_DONE, and the unit is idle again in the
// cycle after the response is loaded. Unused opcodes go from idle to ST_DONE.
// Only one instruction is in flight; req_tready is high while the unit is idle.
// A finished result waits in the response register, so a stalled receiver
// does not keep the unit from taking the next request; that one then waits
// for the register to drain before it retires.
// Reset clears HI and LO of both pipes to zero and empties the response.
`default_nettype none

module hilo_multiply_divide_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // rs_value [31:0], rt_value [63:32], dest_reg [68:64], zero fill above
   input  wire logic [71:0] req_tdata,
   // opcode [2:0], pipe_select [3]
   input  wire logic [3:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // hi_result [31:0], lo_result [63:32], dest_index [68:64], zero fill above
   output logic [71:0]      rsp_tdata,
   // dest_write
   output logic             rsp_tuser
);
   import hlmdu_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_RUN  = 5'b00010,
      ST_FIX  = 5'b00100,
      ST_ACC  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [OP_W-1:0]   op_ff;
   logic              pipe_ff;
   logic [DATA_W-1:0] rs_ff, rt_ff;
   logic [REG_W-1:0]  rd_ff;
   logic [PROD_W-1:0] res_ff, res_in;
   logic [DATA_W-1:0] hi_ff [2];
   logic [DATA_W-1:0] lo_ff [2];
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_hi_ff, rsp_lo_ff;
   logic              rsp_dw_ff;
   logic [REG_W-1:0]  rsp_idx_ff;

   logic [OP_W-1:0]   req_op;
   logic [DATA_W-1:0] req_rs, req_rt, rs_mag, rt_mag;
   logic              accept, mul_start, div_start, mul_done, div_done;
   logic [PROD_W-1:0] product, sum, acc;
   logic [DATA_W-1:0] quotient, remainder, q_fix, r_fix, lo_dz;
   logic              sgn, load_rsp, dest_wr;

   assign req_op = req_tuser[OP_W-1:0];
   assign req_rs = req_tdata[DATA_W-1:0];
   assign req_rt = req_tdata[2*DATA_W-1:DATA_W];
   assign rs_mag = (is_signed_op(req_op) && req_rs[DATA_W-1]) ? -req_rs : req_rs;
   assign rt_mag = (is_signed_op(req_op) && req_rt[DATA_W-1]) ? -req_rt : req_rt;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign mul_start  = accept && is_mul_op(req_op);
   assign div_start  = accept && is_div_op(req_op);

   hlmdu_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (rs_mag),
      .mplier  (rt_mag),
      .done    (mul_done),
      .product (product)
   );

   hlmdu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (rs_mag),
      .divisor   (rt_mag),
      .done      (div_done),
      .quotient  (quotient),
      .remainder (remainder)
   );

   always_comb begin
      sgn    = is_signed_op(op_ff);
      q_fix  = (sgn && (rs_ff[DATA_W-1] ^ rt_ff[DATA_W-1])) ? -quotient : quotient;
      r_fix  = (sgn && rs_ff[DATA_W-1]) ? -remainder : remainder;
      lo_dz  = (sgn && rs_ff[DATA_W-1]) ? DATA_W'(1) : {DATA_W{1'b1}};
      res_in = res_ff;
      if (is_mul_op(op_ff)) begin
         res_in = (sgn && (rs_ff[DATA_W-1] ^ rt_ff[DATA_W-1])) ? -product : product;
      end else if (rt_ff == '0) begin
         res_in = {rs_ff, lo_dz};
      end else begin
         res_in = {r_fix, q_fix};
      end
      acc      = is_acc_op(op_ff) ? {hi_ff[pipe_ff], lo_ff[pipe_ff]} : '0;
      sum      = res_ff + acc;
      load_rsp = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
      dest_wr  = is_mul_op(op_ff) && (rd_ff != '0);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (is_mul_op(req_op) || is_div_op(req_op)) ? ST_RUN : ST_DONE;
            end
         end
         ST_RUN: begin
            if (mul_done || div_done) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX:  state_in = ST_ACC;
         ST_ACC:  state_in = ST_DONE;
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         hi_ff[0]     <= '0;
         hi_ff[1]     <= '0;
         lo_ff[0]     <= '0;
         lo_ff[1]     <= '0;
      end else begin
         state_ff <= state_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_ACC) begin
            hi_ff[pipe_ff] <= sum[PROD_W-1:DATA_W];
            lo_ff[pipe_ff] <= sum[DATA_W-1:0];
         end
      end
      if (accept) begin
         op_ff   <= req_op;
         pipe_ff <= req_tuser[OP_W];
         rs_ff   <= req_rs;
         rt_ff   <= req_rt;
         rd_ff   <= req_tdata[2*DATA_W+REG_W-1:2*DATA_W];
      end
      if (state_ff == ST_FIX) begin
         res_ff <= res_in;
      end
      if (load_rsp) begin
         rsp_hi_ff  <= hi_ff[pipe_ff];
         rsp_lo_ff  <= lo_ff[pipe_ff];
         rsp_dw_ff  <= dest_wr;
         rsp_idx_ff <= dest_wr ? rd_ff : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_idx_ff, rsp_lo_ff, rsp_hi_ff};
   assign rsp_tuser  = rsp_dw_ff;

endmodule

`default_nettype wire

/* tb/hilo_result_checker.sv */
// Checker for the HI/LO multiply-divide unit: watches both streams, predicts
// the new HI/LO of the chosen pipe for each request and compares responses.
// Depends on hlmdu_pkg.
module hilo_result_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [71:0] req_tdata,
   input  wire logic [3:0]  req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [71:0] rsp_tdata,
   input  wire logic        rsp_tuser,
   output int               fail_count,
   output int               pending_count,
   output int               result_count
);
   import hlmdu_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [DATA_W-1:0] hi;
      logic [DATA_W-1:0] lo;
      logic              wr;
      logic [REG_W-1:0]  idx;
   } hilo_result_type;

   logic [DATA_W-1:0] hi_reg [2];
   logic [DATA_W-1:0] lo_reg [2];
   hilo_result_type   expected_results [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
      result_count  = 0;
   end

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] mismatch on %s in response %0d: got %h, want %h",
               $realtime, field, result_count, got, want);
      fail_count++;
   endtask

   function automatic hilo_result_type predict_hilo(input logic [OP_W-1:0] op,
                                                    input logic pipe,
                                                    input logic [DATA_W-1:0] rs,
                                                    input logic [DATA_W-1:0] rt,
                                                    input logic [REG_W-1:0] rd);
      logic signed [PROD_W-1:0] sa;
      logic signed [PROD_W-1:0] sb;
      logic signed [PROD_W-1:0] quo;
      logic signed [PROD_W-1:0] rem;
      logic [PROD_W-1:0]        prod;
      hilo_result_type          res;
      sa  = {{DATA_W{rs[DATA_W-1]}}, rs};
      sb  = {{DATA_W{rt[DATA_W-1]}}, rt};
      res = '0;
      case (op)
         OP_MULT, OP_MULTU, OP_MADD, OP_MADDU: begin
            if (op == OP_MULT || op == OP_MADD) begin
               prod = sa * sb;
            end else begin
               prod = {{DATA_W{1'b0}}, rs} * {{DATA_W{1'b0}}, rt};
            end
            if (op == OP_MADD || op == OP_MADDU) begin
               prod = prod + {hi_reg[pipe], lo_reg[pipe]};
            end
            hi_reg[pipe] = prod[PROD_W-1:DATA_W];
            lo_reg[pipe] = prod[DATA_W-1:0];
            res.wr  = (rd != '0);
            res.idx = res.wr ? rd : '0;
         end
         OP_DIV: begin
            if (rt == '0) begin
               lo_reg[pipe] = rs[DATA_W-1] ? 32'd1 : 32'hFFFF_FFFF;
               hi_reg[pipe] = rs;
            end else begin
               quo = sa / sb;
               rem = sa % sb;
               lo_reg[pipe] = quo[DATA_W-1:0];
               hi_reg[pipe] = rem[DATA_W-1:0];
            end
         end
         OP_DIVU: begin
            if (rt == '0) begin
               lo_reg[pipe] = 32'hFFFF_FFFF;
               hi_reg[pipe] = rs;
            end else begin
               lo_reg[pipe] = rs / rt;
               hi_reg[pipe] = rs % rt;
            end
         end
         default: begin
         end
      endcase
      res.hi = hi_reg[pipe];
      res.lo = lo_reg[pipe];
      return res;
   endfunction

   always @(posedge clock) begin
      hilo_result_type want;
      if (reset) begin
         hi_reg = '{default: '0};
         lo_reg = '{default: '0};
         expected_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $display("[%0t] response transaction with no request waiting", $realtime);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[31:0] !== want.hi) begin
                  report_mismatch("hi_result", rsp_tdata[31:0], want.hi);
               end
               if (rsp_tdata[63:32] !== want.lo) begin
                  report_mismatch("lo_result", rsp_tdata[63:32], want.lo);
               end
               if (rsp_tuser !== want.wr) begin
                  report_mismatch("dest_write", {31'd0, rsp_tuser}, {31'd0, want.wr});
               end
               if (rsp_tdata[68:64] !== want.idx) begin
                  report_mismatch("dest_index", {27'd0, rsp_tdata[68:64]}, {27'd0, want.idx});
               end
            end
            result_count++;
         end
         if (req_tvalid && req_tready) begin
            expected_results.push_back(predict_hilo(req_tuser[2:0], req_tuser[3],
                                                    req_tdata[31:0], req_tdata[63:32],
                                                    req_tdata[68:64]));
         end
      end
      pending_count = expected_results.size();
   end

endmodule

/* tb/testbench.sv */
// Top of the testbench for the HI/LO multiply-divide unit: clock, reset,
// request stimulus, response back-pressure and the final verdict.
// Depends on hlmdu_pkg, hilo_multiply_divide_unit and hilo_result_checker.
module testbench;
   import hlmdu_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;
   localparam int RANDOM_ITEMS = 1425;
   localparam int HOLD_START   = 3000;
   localparam int HOLD_LEN     = 600;

   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata  = '0;
   logic [3:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        rsp_tuser;
   int          fail_count;
   int          pending_count;
   int          result_count;
   int          rx_cycle   = 0;
   rx_mode_type rx_mode    = RX_OPEN;

   hilo_multiply_divide_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   hilo_result_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .result_count  (result_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_cycle   <= 0;
      end else begin
         rx_cycle <= rx_cycle + 1;
         if (rx_cycle % 64 == 0) begin
            rx_mode <= rx_mode_type'($urandom_range(0, 3));
         end
         if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN) begin
            rsp_tready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_OPEN:   rsp_tready <= 1'b1;
               RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
               default:   rsp_tready <= rx_cycle[2];
            endcase
         end
      end
   end

   task automatic send_item(input logic [OP_W-1:0] op, input logic pipe,
                            input logic [31:0] rs, input logic [31:0] rt,
                            input logic [REG_W-1:0] rd);
      req_tdata  <= {3'b000, rd, rt, rs};
      req_tuser  <= {pipe, op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0:       return 32'h0000_0000;
         1:       return 32'h0000_0001;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h8000_0000;
         4:       return 32'h7FFF_FFFF;
         5:       return $urandom_range(0, 15);
         6:       return -$urandom_range(1, 16);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int               burst_left;
      int               gap;
      logic [OP_W-1:0]  op;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(OP_MULT,  1'b0, 32'h8000_0000, 32'h8000_0000, 5'd31);
      send_item(OP_MULT,  1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0);
      send_item(OP_MULTU, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1);
      send_item(OP_MULTU, 1'b0, 32'h0000_0000, 32'hDEAD_BEEF, 5'd17);
      send_item(OP_MADD,  1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd2);
      send_item(OP_MADD,  1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 5'd0);
      send_item(OP_MADDU, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd30);
      send_item(OP_MADDU, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
      send_item(OP_DIV,   1'b0, 32'hFFFF_FFF9, 32'h0000_0000, 5'd3);
      send_item(OP_DIV,   1'b1, 32'h0000_0007, 32'h0000_0000, 5'd0);
      send_item(OP_DIV,   1'b0, 32'h0000_0000, 32'h0000_0000, 5'd31);
      send_item(OP_DIVU,  1'b1, 32'h8000_0000, 32'h0000_0000, 5'd4);
      send_item(OP_DIV,   1'b0, 32'h8000_0000, 32'hFFFF_FFFF, 5'd5);
      send_item(OP_DIV,   1'b1, 32'hFFFF_FFF9, 32'h0000_0002, 5'd0);
      send_item(OP_DIV,   1'b0, 32'h0000_0007, 32'hFFFF_FFFE, 5'd6);
      send_item(OP_DIVU,  1'b0, 32'hFFFF_FFFF, 32'h0000_0001, 5'd7);
      send_item(OP_DIVU,  1'b1, 32'h8000_0000, 32'hFFFF_FFFF, 5'd8);
      send_item(OP_DIVU,  1'b0, 32'h0000_0003, 32'h0000_0007, 5'd9);
      send_item(OP_SPARE_A, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
      send_item(OP_SPARE_B, 1'b1, 32'h1234_5678, 32'h9ABC_DEF0, 5'd10);
      send_item(OP_MADD,  1'b1, 32'hFFFF_FFFF, 32'h0000_0001, 5'd11);
      send_item(OP_MULTU, 1'b0, 32'h8000_0000, 32'h0000_0002, 5'd16);

      burst_left = $urandom_range(1, 10);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if ($urandom_range(0, 99) < 2) begin
            op = $urandom_range(0, 1) ? OP_SPARE_B : OP_SPARE_A;
         end else begin
            op = OP_W'($urandom_range(0, 5));
         end
         send_item(op, 1'($urandom_range(0, 1)), pick_operand(), pick_operand(),
                   REG_W'($urandom_range(0, 31)));
         burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      req_tvalid <= 1'b0;

      do @(posedge clock); while (pending_count != 0);
      repeat (40) @(posedge clock);

      $display("Checked %0d responses from %0d requests: all six operations on both pipes,",
               result_count, RANDOM_ITEMS + 22);
      $display("divide by zero, signed overflow, accumulate chains and unused opcodes.");
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d responses still expected", pending_count);
      $display("Test completed with failures");
      $finish;
   end

endmodule
